// ----- design/sparse_sequence_window_table_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sequence window table
// Clocked on clk_i, held off while rst_ni is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SPARSE_SEQUENCE_WINDOW_TABLE_ASSERT_SVH
`define SPARSE_SEQUENCE_WINDOW_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every edge out of reset
`define SSWT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// condition must never be seen
`define SSWT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define SSWT_ASSERT(lbl, prop)
`define SSWT_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ----- design/ssw_pkg.sv -----
// ----------------------------------------------------------------------------
// ssw_pkg
// Types and constants shared by the sequence window table modules.
// ----------------------------------------------------------------------------
package ssw_pkg;

  localparam int CAPACITY     = 32;
  localparam int PAYLOAD_BITS = 64;
  localparam int CNT_W        = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    OP_ADMIT  = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_DEPTH  = 3'd2,
    OP_LIST   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_HIT,
    S_ECMP,
    S_EVICT,
    S_SCAN,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] seq_key;
    logic [31:0] entry_label;
    logic        entry_fresh;
    logic [63:0] entry_payload;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic        present;
    logic [31:0] found_label;
    logic        found_fresh;
    logic [63:0] found_payload;
    logic [5:0]  run_depth;
    logic [31:0] listed_key;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [31:0]             key;
    logic [31:0]             label;
    logic                    fresh;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // running minimum handed from cell to cell
  typedef struct packed {
    logic        any;
    logic [31:0] m;
  } min_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic [31:0] bkey;
    logic [31:0] prev;
    logic        have_prev;
    logic        clr;
    entry_t      wdata;
  } cell_ctl_t;

endpackage

// ----- design/ssw_cell.sv -----
// ----------------------------------------------------------------------------
// ssw_cell
// One table slot: stores an entry, flags a key match, and folds its key into
// the running minimum that moves down the chain.
// ----------------------------------------------------------------------------
module ssw_cell import ssw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  logic      wr_i,
  input  min_t      min_i,
  output min_t      min_o,
  output logic      valid_o,
  output logic      hit_o,
  output entry_t    entry_o
);

  logic   valid_q;
  logic   hit_q;
  min_t   min_q;
  min_t   min_d;
  entry_t entry_q;
  logic   take;

  // candidate: above the previous listed key and below the minimum so far
  assign take = valid_q && (!ctl_i.have_prev || (entry_q.key > ctl_i.prev)) &&
                (!min_i.any || (entry_q.key < min_i.m));

  always_comb begin
    min_d = min_i;
    if (take) begin
      min_d.any = 1'b1;
      min_d.m   = entry_q.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
      min_q   <= '0;
    end else begin
      if (ctl_i.clr) begin
        valid_q <= 1'b0;
      end else if (wr_i) begin
        valid_q <= 1'b1;
      end
      hit_q <= valid_q && (entry_q.key == ctl_i.bkey);
      min_q <= min_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      entry_q <= ctl_i.wdata;
    end
  end

  assign min_o   = min_q;
  assign valid_o = valid_q;
  assign hit_o   = hit_q;
  assign entry_o = entry_q;

endmodule

// ----- design/ssw_chain.sv -----
// ----------------------------------------------------------------------------
// ssw_chain
// Row of slot cells with the slot pickers and the matched-entry read mux.
// ----------------------------------------------------------------------------
module ssw_chain import ssw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctl_t           ctl_i,
  input  logic [CAPACITY-1:0] wr_i,
  output logic [CAPACITY-1:0] valid_o,
  output logic [CAPACITY-1:0] hit_o,
  output logic                any_hit_o,
  output logic [CAPACITY-1:0] free_oh_o,
  output logic [CAPACITY-1:0] evict_oh_o,
  output entry_t              rd_o,
  output min_t                tail_o
);

  min_t   link [CAPACITY+1];
  entry_t ents [CAPACITY];
  logic [ENTRY_W-1:0] rd;

  assign link[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ssw_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_i),
      .wr_i    (wr_i[g]),
      .min_i   (link[g]),
      .min_o   (link[g+1]),
      .valid_o (valid_o[g]),
      .hit_o   (hit_o[g]),
      .entry_o (ents[g])
    );
  end

  assign tail_o    = link[CAPACITY];
  assign any_hit_o = |hit_o;
  // lowest free slot, lowest matching slot (slot 0 if none)
  assign free_oh_o = ~valid_o & (valid_o + CAPACITY'(1));
  assign evict_oh_o = any_hit_o ? (hit_o & (~hit_o + CAPACITY'(1))) : CAPACITY'(1);

  // keys are unique, so at most one hit
  always_comb begin
    rd = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd = rd | (ents[i] & {ENTRY_W{hit_o[i]}});
    end
  end

  assign rd_o = entry_t'(rd);

endmodule

// ----- design/sparse_sequence_window_table.sv -----
// ----------------------------------------------------------------------------
// sparse_sequence_window_table
// Reorder table of CAPACITY entries keyed by 32-bit sequence number, with
// admit, lookup, depth-from-cursor, ascending list and clear.
// ----------------------------------------------------------------------------
//
//  port group   dir  handshake                   word
//  in_*         in   in_valid_i / in_stall_o     in_word_t  (one command)
//  out_*        out  out_valid_o / out_stall_i   out_word_t (one result)
//
// Steps: one command at a time, from the accepting idle state to the output
// register load. Lookup and plain admit pass through accept, compare, hit
// and output; clear, empty list and unused opcodes go from accept straight
// to output. Depth repeats compare and hit for each consecutive key found
// (up to CAPACITY). Admit into a full table adds an evict compare, the slot
// write and a pass of the minimum down the cell chain. List makes one chain
// pass plus an output state per key emitted.
// Reset clears the valid bits and counters; slot contents are not cleared.
// in_stall_o is high while a command is in work; a stalled result sits in
// the output register and holds the sequencer in its output state.
// ----------------------------------------------------------------------------
module sparse_sequence_window_table import ssw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  `include "sparse_sequence_window_table_assert.svh"

  state_e state_q, state_d;

  logic [2:0]              op_q, op_d;
  logic [31:0]             key_q, key_d;
  logic [31:0]             label_q, label_d;
  logic                    fresh_q, fresh_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic [31:0]             bkey_q, bkey_d;
  logic [31:0]             prev_q, prev_d;
  logic                    have_prev_q, have_prev_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;     // chain pass timer
  logic [CNT_W-1:0]        lcnt_q, lcnt_d;   // keys listed so far
  logic [CNT_W-1:0]        depth_q, depth_d;
  logic [CNT_W-1:0]        held_q, held_d;
  logic [31:0]             low_q, low_d;
  logic [31:0]             high_q, high_d;
  out_word_t               res_q, res_d;
  out_word_t               out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  cell_ctl_t           ctl;
  logic [CAPACITY-1:0] wr;
  logic [CAPACITY-1:0] valid_v, hit_v, free_oh, evict_oh;
  logic                any_hit;
  entry_t              rd;
  min_t                tail;

  logic out_free, scan_done, depth_go, key_max, is_full, below_low, list_more;

  ssw_chain u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .wr_i       (wr),
    .valid_o    (valid_v),
    .hit_o      (hit_v),
    .any_hit_o  (any_hit),
    .free_oh_o  (free_oh),
    .evict_oh_o (evict_oh),
    .rd_o       (rd),
    .tail_o     (tail)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign scan_done = (cnt_q == CNT_W'(CAPACITY));
  assign depth_go  = any_hit && (depth_q < CNT_W'(CAPACITY));
  assign key_max   = (bkey_q == 32'hFFFF_FFFF);
  assign is_full   = (held_q == CNT_W'(CAPACITY));
  assign below_low = (key_q < low_q);
  assign list_more = (op_q == OP_LIST) && !res_q.last;

  function automatic logic [5:0] sat_depth(input logic [CNT_W-1:0] d);
    if (32'(d) > 32'd63) begin
      return 6'd63;
    end
    return 6'(d);
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_word_i.opcode)
            OP_ADMIT, OP_LOOKUP, OP_DEPTH: state_d = S_CMP;
            OP_LIST: state_d = (held_q == '0) ? S_OUT : S_SCAN;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_CMP: state_d = S_HIT;
      S_HIT: begin
        unique case (op_q)
          OP_ADMIT: state_d = (!any_hit && is_full && !below_low) ? S_ECMP : S_OUT;
          OP_DEPTH: state_d = (depth_go && !key_max) ? S_CMP : S_OUT;
          default:  state_d = S_OUT;
        endcase
      end
      S_ECMP:  state_d = S_EVICT;
      S_EVICT: state_d = S_SCAN;
      S_SCAN:  state_d = scan_done ? S_OUT : S_SCAN;
      S_OUT: begin
        if (out_free) begin
          state_d = list_more ? S_SCAN : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and cell control
  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    label_d     = label_q;
    fresh_d     = fresh_q;
    pay_d       = pay_q;
    bkey_d      = bkey_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    cnt_d       = cnt_q;
    lcnt_d      = lcnt_q;
    depth_d     = depth_q;
    held_d      = held_q;
    low_d       = low_q;
    high_d      = high_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr          = '0;

    ctl           = '0;
    ctl.bkey      = bkey_q;
    ctl.prev      = prev_q;
    ctl.have_prev = have_prev_q;
    ctl.wdata.key     = key_q;
    ctl.wdata.label   = label_q;
    ctl.wdata.fresh   = fresh_q;
    ctl.wdata.payload = pay_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d        = in_word_i.opcode;
          key_d       = in_word_i.seq_key;
          label_d     = in_word_i.entry_label;
          fresh_d     = in_word_i.entry_fresh;
          pay_d       = in_word_i.entry_payload[PAYLOAD_BITS-1:0];
          bkey_d      = in_word_i.seq_key;
          have_prev_d = 1'b0;
          cnt_d       = '0;
          lcnt_d      = '0;
          depth_d     = '0;
          res_d       = '0;
          res_d.last  = 1'b1;
          if (in_word_i.opcode == OP_CLEAR) begin
            ctl.clr = 1'b1;
            held_d  = '0;
            low_d   = '0;
            high_d  = '0;
          end
        end
      end
      S_HIT: begin
        unique case (op_q)
          OP_ADMIT: begin
            if (!any_hit) begin
              res_d.accepted = 1'b1;
              if (held_q == '0) begin
                wr     = free_oh;
                held_d = CNT_W'(1);
                low_d  = key_q;
                high_d = key_q;
              end else if (!is_full) begin
                wr     = free_oh;
                held_d = held_q + CNT_W'(1);
                if (key_q < low_q) begin
                  low_d = key_q;
                end
                if (key_q > high_q) begin
                  high_d = key_q;
                end
              end else if (!below_low) begin
                bkey_d = low_q;   // find the slot of the lowest key
              end
            end
          end
          OP_LOOKUP: begin
            // read mux gives zero on a miss
            res_d.present       = any_hit;
            res_d.found_fresh   = any_hit && rd.fresh;
            res_d.found_payload = 64'(rd.payload);
            res_d.found_label   = rd.label;
          end
          OP_DEPTH: begin
            if (depth_go) begin
              depth_d = depth_q + CNT_W'(1);
              if (key_max) begin
                res_d.run_depth = sat_depth(depth_q + CNT_W'(1));
              end else begin
                bkey_d = bkey_q + 32'd1;
              end
            end else begin
              res_d.run_depth = sat_depth(depth_q);
            end
          end
          default: ;
        endcase
      end
      S_EVICT: begin
        wr          = evict_oh;
        have_prev_d = 1'b0;
        cnt_d       = '0;
        if (key_q > high_q) begin
          high_d = key_q;
        end
      end
      S_SCAN: begin
        if (!scan_done) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else if (op_q == OP_LIST) begin
          res_d            = '0;
          res_d.present    = 1'b1;
          res_d.listed_key = tail.m;
          res_d.last       = (lcnt_q + CNT_W'(1)) == held_q;
          lcnt_d           = lcnt_q + CNT_W'(1);
          prev_d           = tail.m;
          have_prev_d      = 1'b1;
        end else begin
          low_d = tail.any ? tail.m : 32'd0;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          cnt_d       = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      held_q      <= '0;
      low_q       <= '0;
      high_q      <= '0;
      cnt_q       <= '0;
      lcnt_q      <= '0;
      depth_q     <= '0;
      have_prev_q <= 1'b0;
      op_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      held_q      <= held_d;
      low_q       <= low_d;
      high_q      <= high_d;
      cnt_q       <= cnt_d;
      lcnt_q      <= lcnt_d;
      depth_q     <= depth_d;
      have_prev_q <= have_prev_d;
      op_q        <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    label_q <= label_d;
    fresh_q <= fresh_d;
    pay_q   <= pay_d;
    bkey_q  <= bkey_d;
    prev_q  <= prev_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `SSWT_ASSERT(a_held_cap, held_q <= CNT_W'(CAPACITY))
  `SSWT_ASSERT(a_held_count, (state_q == S_IDLE) |-> (32'(held_q) == $countones(valid_v)))
  `SSWT_ASSERT(a_unique_hit, $onehot0(hit_v))
  `SSWT_ASSERT_NEVER(a_low_high, (state_q == S_IDLE) && (held_q != '0) && (low_q > high_q))

endmodule

// ----- tb/tb_sparse_sequence_window_table.sv -----
// ----------------------------------------------------------------------------
// tb_sparse_sequence_window_table
// Drives admit, lookup, depth, list and clear commands into the sequence
// window table and checks every result word against a behavioral table model.
// ----------------------------------------------------------------------------
module tb_sparse_sequence_window_table;
  timeunit 1ns;
  timeprecision 1ps;
  import ssw_pkg::*;

  // Table model plus the queue of result words still owed by the block.
  class window_scoreboard;
    bit          held [CAPACITY];
    logic [31:0] keys [CAPACITY];
    logic [31:0] labels [CAPACITY];
    logic        freshs [CAPACITY];
    logic [63:0] payloads [CAPACITY];
    int          held_cnt;
    logic [31:0] low_key;
    logic [31:0] high_key;
    out_word_t   owed_q[$];
    int          mismatches;

    function void wipe();
      foreach (held[i]) held[i] = 0;
      held_cnt = 0;
      low_key  = '0;
      high_key = '0;
    endfunction

    function void owe(out_word_t r);
      owed_q.insert(owed_q.size(), r);
    endfunction

    function int slot_of(logic [31:0] k);
      foreach (held[i]) if (held[i] && keys[i] == k) return i;
      return -1;
    endfunction

    function bit key_held(logic [31:0] k);
      return slot_of(k) >= 0;
    endfunction

    function void put(int s, in_word_t w);
      held[s]     = 1;
      keys[s]     = w.seq_key;
      labels[s]   = w.entry_label;
      freshs[s]   = w.entry_fresh;
      payloads[s] = w.entry_payload;
    endfunction

    function bit admit(in_word_t w);
      int s;
      bit any;
      if (slot_of(w.seq_key) >= 0) return 0;
      if (held_cnt < CAPACITY) begin
        s = -1;
        foreach (held[i]) if (!held[i] && s < 0) s = i;
        put(s, w);
        if (held_cnt == 0 || w.seq_key < low_key) low_key = w.seq_key;
        if (held_cnt == 0 || w.seq_key > high_key) high_key = w.seq_key;
        held_cnt++;
        return 1;
      end
      // full: a key below the lowest is evicted at once
      if (w.seq_key < low_key) return 1;
      s = slot_of(low_key);
      if (s < 0) s = 0;
      put(s, w);
      if (w.seq_key > high_key) high_key = w.seq_key;
      any = 0;
      foreach (held[i])
        if (held[i] && (!any || keys[i] < low_key)) begin
          low_key = keys[i];
          any = 1;
        end
      return 1;
    endfunction

    // work out the result words of one accepted command
    function void note_command(in_word_t w);
      out_word_t r;
      int s;
      int d;
      logic [32:0] at;
      logic [31:0] prev;
      logic [31:0] m;
      bit have_prev;
      bit any;
      int n;
      r = '0;
      r.last = 1;
      case (w.opcode)
        OP_ADMIT: r.accepted = admit(w);
        OP_LOOKUP: begin
          s = slot_of(w.seq_key);
          if (s >= 0) begin
            r.present       = 1;
            r.found_label   = labels[s];
            r.found_fresh   = freshs[s];
            r.found_payload = payloads[s];
          end
        end
        OP_DEPTH: begin
          d  = 0;
          at = {1'b0, w.seq_key};
          while (at <= 33'hFFFF_FFFF && d < CAPACITY && key_held(at[31:0])) begin
            d++;
            at++;
          end
          r.run_depth = 6'(d);
        end
        OP_LIST: begin
          n = 0;
          have_prev = 0;
          prev = '0;
          forever begin
            any = 0;
            m = '0;
            foreach (held[i])
              if (held[i] && (!have_prev || keys[i] > prev) && (!any || keys[i] < m)) begin
                m = keys[i];
                any = 1;
              end
            if (!any) break;
            r = '0;
            r.present    = 1;
            r.listed_key = m;
            owe(r);
            n++;
            prev = m;
            have_prev = 1;
          end
          if (n == 0) begin
            r = '0;
            r.last = 1;
            owe(r);
          end else begin
            owed_q[owed_q.size()-1].last = 1;
          end
          return;
        end
        OP_CLEAR: wipe();
        default: ;
      endcase
      owe(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = owed_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  window_scoreboard sb;
  longint unsigned  cycle_cnt = 0;
  bit               quiet_tail;   // no idling near the end
  bit               hold_rx;      // long receiver hold-off request
  bit               hold_done;    // hold-off already served
  logic [31:0]      key_base;

  sparse_sequence_window_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one command word and hold it until the block takes it.
  task automatic send_word(in_word_t w);
    int gap;
    if (!quiet_tail && $urandom_range(3) == 0) begin
      gap = $urandom_range(16, 1);
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(w);
  endtask

  task automatic send_op(op_e op, logic [31:0] k);
    in_word_t w;
    w.opcode        = op;
    w.seq_key       = k;
    w.entry_label   = $urandom;
    w.entry_fresh   = 1'($urandom_range(1));
    w.entry_payload = {$urandom, $urandom};
    send_word(w);
  endtask

  // keys mostly clustered near a moving base so runs and hits happen
  function automatic logic [31:0] pick_key();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(40);
      2: return $urandom_range(40);
      default: return key_base + $urandom_range(48);
    endcase
  endfunction

  // Receiver: random stall bursts, plus one long hold-off when asked.
  initial begin
    hold_done = 0;
    out_stall_i <= 1;
    @(posedge rst_ni);
    forever begin
      if (hold_rx && !hold_done) begin
        out_stall_i <= 1;
        repeat (400) @(posedge clk_i);
        hold_done = 1;
      end else if (!quiet_tail && $urandom_range(3) == 0) begin
        out_stall_i <= 1;
        repeat ($urandom_range(16, 1)) @(posedge clk_i);
      end else begin
        out_stall_i <= 0;
        repeat ($urandom_range(16, 1)) @(posedge clk_i);
      end
    end
  end

  // Result monitor: check every accepted result word.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_word_o);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3_000_000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    int i;
    int op_pick;
    sb = new();
    sb.wipe();
    quiet_tail = 0;
    hold_rx    = 0;
    key_base   = 32'h1000;
    rst_ni     = 0;
    in_valid_i = 0;
    in_word_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty list, misses, field extremes, duplicate, ceiling depth.
    send_op(OP_LIST, 0);
    send_op(OP_LOOKUP, 5);
    send_op(OP_DEPTH, 0);
    w = '{OP_ADMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
    send_word(w);
    w = '{OP_ADMIT, 32'hFFFF_FFFE, 32'h0, 1'b0, 64'h0};
    send_word(w);
    w = '{OP_ADMIT, 32'h0, 32'hA5A5_5A5A, 1'b1, 64'h0123_4567_89AB_CDEF};
    send_word(w);
    send_op(OP_ADMIT, 32'hFFFF_FFFF);           // duplicate key
    send_op(OP_LOOKUP, 32'hFFFF_FFFF);
    send_op(OP_LOOKUP, 32'h0);
    send_op(OP_DEPTH, 32'hFFFF_FFFE);           // stops at the key ceiling
    send_op(OP_LIST, 0);
    w = '0;
    w.opcode = 3'd5;                            // unused opcodes
    send_word(w);
    w.opcode = 3'd7;
    send_word(w);
    send_op(OP_CLEAR, 0);
    send_op(OP_LIST, 0);
    // Fill past capacity: full-table eviction, then a key below the lowest.
    for (i = 0; i < CAPACITY + 2; i++) send_op(OP_ADMIT, 32'd100 + i);
    send_op(OP_ADMIT, 32'd50);
    send_op(OP_DEPTH, 32'd102);
    send_op(OP_LIST, 0);
    send_op(OP_LOOKUP, 32'd100);

    // Long receiver hold-off while commands keep coming.
    hold_rx = 1;
    for (i = 0; i < 12; i++) send_op(OP_LOOKUP, 32'd100 + i);

    // Random phase.
    for (i = 0; i < 265; i++) begin
      if (i == 225) quiet_tail = 1;
      if ($urandom_range(30) == 0) key_base = $urandom;
      op_pick = $urandom_range(99);
      if (op_pick < 50) send_op(OP_ADMIT, pick_key());
      else if (op_pick < 72) send_op(OP_LOOKUP, pick_key());
      else if (op_pick < 86) send_op(OP_DEPTH, pick_key());
      else if (op_pick < 94) send_op(OP_LIST, 0);
      else if (op_pick < 97) send_op(OP_CLEAR, 0);
      else begin
        w = '0;
        w.opcode = 3'($urandom_range(7, 5));
        w.seq_key = $urandom;
        send_word(w);
      end
    end
    in_valid_i <= 0;

    // Drain, then allow for trailing activity.
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
